// ===== rtl/assert_macros.svh =====
// Assertion macros included by the top level of the chroma offset block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising edge of clk_i outside reset.
`define CMYCO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an expression is true at every rising edge of clk_i outside reset.
`define CMYCO_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`else

`define CMYCO_ASSERT(lbl, prop, msg)
`define CMYCO_ASSERT_ALWAYS(lbl, expr, msg)

`endif

`endif

// ===== rtl/cmyco_pkg.sv =====
// Package with the widths and constants of the CMY chroma offset block.
package cmyco_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned OffW = 8;
  localparam int unsigned NumStages = 5;

  // Grey weights and bias.
  localparam int unsigned CoefC = 77;
  localparam int unsigned CoefM = 151;
  localparam int unsigned CoefY = 28;
  localparam int unsigned GreyBias = 65280;

  // Chroma scale factors: 16 * 28 and 16 * 11.
  localparam int signed ScaleCb = 448;
  localparam int signed ScaleCr = 176;

  // Rebuild factors for cyan and yellow.
  localparam int unsigned RebuildCr = 22;
  localparam int unsigned RebuildCb = 28;

  // Reciprocals: floor(114 v / 1000), floor(299 v / 1000) with an 18-bit shift,
  // and floor(1000 v / 587) with a 16-bit shift; exact for any byte v.
  localparam int unsigned RecipY = 29885;
  localparam int unsigned RecipC = 78382;
  localparam int unsigned RecipShift = 18;
  localparam int unsigned RecipQ = 111646;
  localparam int unsigned RecipQShift = 16;

  typedef logic [PixW-1:0] pix_t;
  typedef logic signed [OffW-1:0] off_t;

endpackage

// ===== rtl/cmy_chroma_offset_effect.sv =====
// Top level of the CMY chroma offset block: five-stage pixel pipeline.
//
// Use: pixels enter on the input channel (in_valid_i / in_ready_o) as three
// bytes cyan, magenta and yellow, and recoloured pixels leave on the output
// channel (out_valid_o / out_ready_i) in the same order, one result per item.
// The signed saturation offset is written over its own channel
// (cfg_valid_i / cfg_ready_o), which always accepts; it should only change
// while the pipeline is empty.
// A result is shown once its item has passed through the five pipeline
// registers; the throughput is one item per cycle while the output is not
// stalled.
// Each stage holds its item until the stage after it has room, so a stalled
// receiver backs the pipeline up stage by stage, and bubbles are closed up
// while the output waits, without losing or repeating an item.
// Reset empties the pipeline and sets the offset to zero.
module cmy_chroma_offset_effect (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  cmyco_pkg::off_t   saturation_offset_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmyco_pkg::pix_t   cyan_in_i,
  input  cmyco_pkg::pix_t   magenta_in_i,
  input  cmyco_pkg::pix_t   yellow_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmyco_pkg::pix_t   cyan_out_o,
  output cmyco_pkg::pix_t   magenta_out_o,
  output cmyco_pkg::pix_t   yellow_out_o
);
  import cmyco_pkg::*;

  `include "assert_macros.svh"

  off_t off_q;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages:0]   rdy;

  // Stage 1: grey level.
  pix_t grey1_q, grey1_d, c1_q, y1_q;
  // Stage 2: clamped chroma terms.
  pix_t grey2_q, cb2_q, cb2_d, cr2_q, cr2_d;
  // Stage 3: new cyan and yellow.
  pix_t grey3_q, cyo3_q, cyo3_d, yeo3_q, yeo3_d;
  // Stage 4: weighted cyan and yellow.
  pix_t grey4_q, cyo4_q, yeo4_q;
  logic [4:0] fy4_q, fy4_d;
  logic [6:0] fc4_q, fc4_d;
  // Stage 5: new magenta.
  pix_t cyo5_q, yeo5_q, mgo5_q, mgo5_d;

  logic [16:0] wsum;
  logic [16:0] gdiff;
  logic signed [9:0]  base_cb, base_cr;
  logic signed [18:0] cbx, crx;
  logic [12:0] cr_prod, cb_prod;
  logic [9:0]  cy_sum, ye_sum;
  logic [22:0] fy_prod;
  logic [24:0] fc_prod;
  logic signed [9:0] t5;
  logic [7:0]  mag5;
  logic [24:0] q_prod;
  logic [8:0]  qm5;
  logic [7:0]  q5;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_valid_i) begin
      off_q <= saturation_offset_i;
    end
  end

  // Each stage takes a new item when it is empty or its successor moves on.
  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    if (rdy[0]) begin
      vld_d[0] = in_valid_i;
    end else begin
      vld_d[0] = vld_q[0];
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    wsum = 17'(cyan_in_i) * 17'(CoefC) + 17'(magenta_in_i) * 17'(CoefM)
         + 17'(yellow_in_i) * 17'(CoefY);
    gdiff = 17'(GreyBias) - wsum;
    grey1_d = gdiff[15:8];
  end

  always_comb begin
    base_cb = 10'sd255 - $signed({2'b00, y1_q}) - $signed({2'b00, grey1_q});
    base_cr = 10'sd255 - $signed({2'b00, c1_q}) - $signed({2'b00, grey1_q});
    cbx = 19'(base_cb) * 19'(ScaleCb) + 19'(off_q);
    crx = 19'(base_cr) * 19'(ScaleCr) + 19'(off_q);
    if (cbx < 0) begin
      cb2_d = '0;
    end else if (cbx > 19'sd255) begin
      cb2_d = '1;
    end else begin
      cb2_d = cbx[7:0];
    end
    if (crx < 0) begin
      cr2_d = '0;
    end else if (crx > 19'sd255) begin
      cr2_d = '1;
    end else begin
      cr2_d = crx[7:0];
    end
  end

  always_comb begin
    cr_prod = 13'(cr2_q) * 13'(RebuildCr);
    cb_prod = 13'(cb2_q) * 13'(RebuildCb);
    cy_sum  = 10'(cr_prod[12:4]) + 10'(grey2_q);
    ye_sum  = 10'(cb_prod[12:4]) + 10'(grey2_q);
    cyo3_d  = ~cy_sum[7:0];
    yeo3_d  = ~ye_sum[7:0];
  end

  always_comb begin
    fy_prod = 23'(yeo3_q) * 23'(RecipY);
    fc_prod = 25'(cyo3_q) * 25'(RecipC);
    fy4_d   = 5'(fy_prod >> RecipShift);
    fc4_d   = 7'(fc_prod >> RecipShift);
  end

  always_comb begin
    t5 = $signed({2'b00, grey4_q}) - $signed({5'b00000, fy4_q})
       - $signed({3'b000, fc4_q});
    mag5 = t5[9] ? 8'(-t5) : t5[7:0];
    q_prod = 25'(mag5) * 25'(RecipQ);
    qm5 = 9'(q_prod >> RecipQShift);
    q5 = t5[9] ? (8'd0 - qm5[7:0]) : qm5[7:0];
    mgo5_d = ~q5;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      grey1_q <= grey1_d;
      c1_q    <= cyan_in_i;
      y1_q    <= yellow_in_i;
    end
    if (rdy[1]) begin
      grey2_q <= grey1_q;
      cb2_q   <= cb2_d;
      cr2_q   <= cr2_d;
    end
    if (rdy[2]) begin
      grey3_q <= grey2_q;
      cyo3_q  <= cyo3_d;
      yeo3_q  <= yeo3_d;
    end
    if (rdy[3]) begin
      grey4_q <= grey3_q;
      cyo4_q  <= cyo3_q;
      yeo4_q  <= yeo3_q;
      fy4_q   <= fy4_d;
      fc4_q   <= fc4_d;
    end
    if (rdy[4]) begin
      cyo5_q <= cyo4_q;
      yeo5_q <= yeo4_q;
      mgo5_q <= mgo5_d;
    end
  end

  assign out_valid_o   = vld_q[NumStages-1];
  assign cyan_out_o    = cyo5_q;
  assign magenta_out_o = mgo5_q;
  assign yellow_out_o  = yeo5_q;

  `CMYCO_ASSERT(a_full_blocks_input, (&vld_q) && !out_ready_i |-> !in_ready_o,
                "Input accepted while every stage is full and the output stalls.")
  `CMYCO_ASSERT(a_stage2_holds, vld_q[1] && !rdy[2] |=> vld_q[1] && $stable(cb2_q)
                && $stable(cr2_q), "Stalled chroma stage lost or changed its item.")
  `CMYCO_ASSERT(a_out_follows, !out_valid_o && !vld_q[NumStages-2] |=> !out_valid_o,
                "Result appeared without an item in the stage before it.")

endmodule
